### rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SCJI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define SCJI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/scji_pkg.sv
package scji_pkg;

    localparam int LINE_CAPACITY_DEF = 64;

    localparam logic [3:0] REPEAT_ON_RST  = 4'd2;
    localparam logic [3:0] REPEAT_OFF_RST = 4'd3;

    // configuration register indexes
    localparam logic CFG_REPEAT_ON  = 1'b0;
    localparam logic CFG_REPEAT_OFF = 1'b1;

    // result kinds
    localparam logic [3:0] KIND_FRAME    = 4'd0;
    localparam logic [3:0] KIND_VERSION  = 4'd1;
    localparam logic [3:0] KIND_ATTACHED = 4'd2;
    localparam logic [3:0] KIND_DETACHED = 4'd3;
    localparam logic [3:0] KIND_HOLD     = 4'd4;
    localparam logic [3:0] KIND_TAP      = 4'd5;
    localparam logic [3:0] KIND_REPEAT   = 4'd6;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd7;
    localparam logic [3:0] KIND_LEFT_OUT = 4'd8;

    // characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_V     = "v";
    localparam logic [7:0] CH_A     = "a";
    localparam logic [7:0] CH_D     = "d";
    localparam logic [7:0] CH_K     = "k";
    localparam logic [7:0] CH_T     = "t";
    localparam logic [7:0] CH_N     = "n";
    localparam logic [7:0] CH_R     = "r";
    localparam logic [7:0] CH_W     = "w";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_I     = "i";
    localparam logic [7:0] CH_S     = "s";
    localparam logic [7:0] CH_G     = "g";

    typedef enum logic [4:0] {
        PH_FIRST = 5'b00001,
        PH_HEX   = 5'b00010,
        PH_AFTER = 5'b00100,
        PH_DEC   = 5'b01000,
        PH_DONE  = 5'b10000
    } parse_phase_t;

    // finished line handed from the parser to the pad logic
    typedef struct packed {
        logic        done;
        logic [7:0]  cmd_char;
        logic [7:0]  hex_val;
        logic [31:0] dec_val;
    } line_t;

    typedef struct packed {
        logic [3:0]  result_kind;
        logic [7:0]  reply_char;
        logic [15:0] reply_count;
        logic [7:0]  reply_mask;
        logic        driven;
        logic [3:0]  dpad_low;
        logic [3:0]  buttons_low;
    } result_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

### rtl/core/scji_line.sv
module scji_line import scji_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_acc,
    input  logic [7:0] text_byte,
    output line_t      line
);

    localparam int LEN_W = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

    logic [LEN_W-1:0] len_reg, len_next;
    parse_phase_t     phase_reg, phase_next;
    logic [1:0]       hcnt_reg, hcnt_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       hacc_reg, hacc_next;
    logic [31:0]      dacc_reg, dacc_next;

    logic        is_eol;
    logic [4:0]  hv;
    logic [31:0] dacc_step;

    assign is_eol    = (text_byte == CH_LF) || (text_byte == CH_CR);
    assign hv        = hex_value(text_byte);
    // acc * 10 + digit, wraps at 32 bits
    assign dacc_step = (dacc_reg << 3) + (dacc_reg << 1) + {28'd0, text_byte[3:0]};

    assign line.done     = byte_acc && is_eol && (len_reg != '0);
    assign line.cmd_char = cmd_reg;
    assign line.hex_val  = hacc_reg;
    assign line.dec_val  = dacc_reg;

    always_comb begin
        len_next   = len_reg;
        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        cmd_next   = cmd_reg;
        hacc_next  = hacc_reg;
        dacc_next  = dacc_reg;
        if (byte_acc) begin
            if (is_eol) begin
                if (len_reg != '0) begin
                    len_next   = '0;
                    phase_next = PH_FIRST;
                end
            end else if (len_reg < LEN_MAX) begin
                len_next = len_reg + 1'b1;
                case (phase_reg)
                    PH_FIRST: begin
                        cmd_next  = text_byte;
                        hcnt_next = 2'd0;
                        hacc_next = 8'd0;
                        dacc_next = 32'd0;
                        if (text_byte == CH_K || text_byte == CH_T || text_byte == CH_N)
                            phase_next = PH_HEX;
                        else
                            phase_next = PH_DONE;
                    end
                    PH_HEX: begin
                        if (hv[4]) begin
                            hacc_next = {hacc_reg[3:0], hv[3:0]};
                            hcnt_next = hcnt_reg + 2'd1;
                            if (hcnt_reg != 2'd0) phase_next = PH_AFTER;
                        end else begin
                            phase_next = (text_byte == CH_COMMA) ? PH_DEC : PH_DONE;
                        end
                    end
                    PH_AFTER: begin
                        if (text_byte == CH_COMMA) begin
                            phase_next = PH_DEC;
                        end else if (is_digit(text_byte)) begin
                            dacc_next  = dacc_step;
                            phase_next = PH_DEC;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DEC: begin
                        if (is_digit(text_byte)) dacc_next = dacc_step;
                        else                     phase_next = PH_DONE;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            phase_reg <= PH_FIRST;
            hcnt_reg  <= 2'd0;
            cmd_reg   <= 8'd0;
            hacc_reg  <= 8'd0;
            dacc_reg  <= 32'd0;
        end else begin
            len_reg   <= len_next;
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            cmd_reg   <= cmd_next;
            hacc_reg  <= hacc_next;
            dacc_reg  <= dacc_next;
        end
    end

endmodule

### rtl/core/scji_pad.sv
module scji_pad import scji_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       tick_acc,
    input  line_t      line,
    input  logic [3:0] repeat_on,
    input  logic [3:0] repeat_off,
    output logic       res_valid,
    output result_t    res
);

    logic        att_reg, att_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  tmask_reg, tmask_next;
    logic [15:0] trem_reg, trem_next;
    logic [7:0]  rmask_reg, rmask_next;
    logic [15:0] rrem_reg, rrem_next;
    logic [4:0]  rph_reg, rph_next;

    logic [7:0] pressed;
    logic [5:0] ph_inc;
    logic [5:0] ph_limit;

    assign ph_inc   = {1'b0, rph_reg} + 6'd1;
    assign ph_limit = {2'b00, repeat_on} + {2'b00, repeat_off};

    assign pressed = held_reg
                   | ((trem_reg != 16'd0) ? tmask_reg : 8'd0)
                   | (((rrem_reg != 16'd0) && ({1'b0, rph_reg} < {2'b00, repeat_on}))
                      ? rmask_reg : 8'd0);

    assign res_valid = tick_acc || line.done;

    always_comb begin
        att_next   = att_reg;
        held_next  = held_reg;
        tmask_next = tmask_reg;
        trem_next  = trem_reg;
        rmask_next = rmask_reg;
        rrem_next  = rrem_reg;
        rph_next   = rph_reg;
        res        = '0;
        if (tick_acc) begin
            res.result_kind = KIND_FRAME;
            if (!att_reg) begin
                res.buttons_low = 4'hF;
                res.dpad_low    = 4'hF;
            end else begin
                res.buttons_low = ~pressed[3:0];
                res.dpad_low    = ~pressed[7:4];
                res.driven      = 1'b1;
                if (trem_reg != 16'd0) trem_next = trem_reg - 16'd1;
                if (rrem_reg != 16'd0) begin
                    if (ph_inc >= ph_limit) begin
                        rph_next  = 5'd0;
                        rrem_next = rrem_reg - 16'd1;
                    end else begin
                        rph_next = ph_inc[4:0];
                    end
                end
            end
        end else if (line.done) begin
            case (line.cmd_char)
                CH_V: res.result_kind = KIND_VERSION;
                CH_A, CH_D: begin
                    res.result_kind = (line.cmd_char == CH_A) ? KIND_ATTACHED : KIND_DETACHED;
                    att_next   = (line.cmd_char == CH_A);
                    held_next  = 8'd0;
                    tmask_next = 8'd0;
                    trem_next  = 16'd0;
                    rrem_next  = 16'd0;
                    rph_next   = 5'd0;
                end
                CH_K: begin
                    res.result_kind = KIND_HOLD;
                    res.reply_mask  = line.hex_val;
                    held_next       = line.hex_val;
                end
                CH_T: begin
                    res.result_kind = KIND_TAP;
                    res.reply_mask  = line.hex_val;
                    // a zero count still taps for one frame
                    res.reply_count = (line.dec_val != 32'd0) ? line.dec_val[15:0] : 16'd1;
                    tmask_next      = line.hex_val;
                    trem_next       = res.reply_count;
                end
                CH_N: begin
                    res.result_kind = KIND_REPEAT;
                    res.reply_mask  = line.hex_val;
                    res.reply_count = line.dec_val[15:0];
                    rmask_next      = line.hex_val;
                    rrem_next       = line.dec_val[15:0];
                    rph_next        = 5'd0;
                end
                CH_R, CH_W, CH_X, CH_I, CH_S, CH_G: begin
                    res.result_kind = KIND_LEFT_OUT;
                    res.reply_char  = line.cmd_char;
                end
                default: begin
                    res.result_kind = KIND_UNKNOWN;
                    res.reply_char  = line.cmd_char;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            att_reg   <= 1'b0;
            held_reg  <= 8'd0;
            tmask_reg <= 8'd0;
            trem_reg  <= 16'd0;
            rmask_reg <= 8'd0;
            rrem_reg  <= 16'd0;
            rph_reg   <= 5'd0;
        end else begin
            att_reg   <= att_next;
            held_reg  <= held_next;
            tmask_reg <= tmask_next;
            trem_reg  <= trem_next;
            rmask_reg <= rmask_next;
            rrem_reg  <= rrem_next;
            rph_reg   <= rph_next;
        end
    end

endmodule

### rtl/core/scji_obuf.sv
module scji_obuf import scji_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    head_v_reg, head_v_next;
    logic    skid_v_reg, skid_v_next;
    logic    rdy_reg;
    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = head_v_reg && out_ready;
    assign out_valid = head_v_reg;
    assign out_data  = head_reg;
    assign in_ready  = rdy_reg;

    always_comb begin
        head_v_next = head_v_reg;
        skid_v_next = skid_v_reg;
        head_next   = head_reg;
        skid_next   = skid_reg;
        if (!head_v_reg || pop) begin
            if (skid_v_reg) begin
                head_v_next = 1'b1;
                head_next   = skid_reg;
                skid_v_next = push;
                if (push) skid_next = push_data;
            end else begin
                head_v_next = push;
                if (push) head_next = push_data;
            end
        end else if (push) begin
            skid_v_next = 1'b1;
            skid_next   = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
            rdy_reg    <= 1'b0;
        end else begin
            head_v_reg <= head_v_next;
            skid_v_reg <= skid_v_next;
            rdy_reg    <= !skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

### rtl/core/serial_command_joypad_injector_top.sv
// serial command joypad injector
// input stream: each beat is either a received text byte (s_tuser = 0) or a
// frame tick (s_tuser = 1). bytes build command lines ended by cr or lf;
// v, a, d, k<hex>, t<hex>,<dec> and n<hex>,<dec> are parsed as bytes arrive.
// output stream: one beat per frame tick (joypad nibbles, active low, driven
// only while attached) and one beat per finished non-empty line (the reply).
// bytes inside a line and empty lines give no output beat.
// a result beat is registered in the result buffer before m_tvalid shows it.
// throughput: one input beat per cycle while s_tready is high; parse and pad
// updates are a single level of logic between the state registers and the
// two-entry result buffer. stall: the result buffer holds one waiting beat plus
// one skid beat, so an input beat is still taken while a result waits; s_tready
// drops only when both entries are full and comes back the cycle after the receiver takes one.
// reset: aresetn low clears pad state, parser and buffer; s_tready is low
// during reset. repeat_on_frames resets to 2, repeat_off_frames to 3.
// configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 repeat
// on frames, 1 repeat off frames) at the clock edge; write only while idle.
module serial_command_joypad_injector_top import scji_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic [0:0]  s_tuser,    // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] buttons_low, [7:4] dpad_low, [8] driven, [16:9] reply_mask,
    // [32:17] reply_count, [40:33] reply_char, [47:41] zero
    output logic [47:0] m_tdata,
    output logic [3:0]  m_tuser,    // [3:0] result_kind
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata
);

    logic       in_acc;
    logic [3:0] rep_on_reg;
    logic [3:0] rep_off_reg;
    line_t      line;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    // input beat taken this cycle
    assign in_acc = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_on_reg  <= REPEAT_ON_RST;
            rep_off_reg <= REPEAT_OFF_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_REPEAT_ON:  rep_on_reg  <= cfg_wdata;
                CFG_REPEAT_OFF: rep_off_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // line assembly and command parsing
    scji_line #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_line (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_acc  (in_acc && !s_tuser[0]),
        .text_byte (s_tdata),
        .line      (line)
    );

    // pad state, frame results and command replies
    scji_pad u_pad (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_acc   (in_acc && s_tuser[0]),
        .line       (line),
        .repeat_on  (rep_on_reg),
        .repeat_off (rep_off_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register with skid entry
    scji_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tuser = out_res.result_kind;
    assign m_tdata = {7'd0, out_res.reply_char, out_res.reply_count, out_res.reply_mask,
                      out_res.driven, out_res.dpad_low, out_res.buttons_low};

endmodule

### rtl/core/scji_checker.sv
`include "assert_macros.svh"

module scji_checker import scji_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // a waiting result beat keeps its payload
    `SCJI_ASSERT_NXT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result beat changed while stalled")

    // a frame tick taken while no result waits shows up in the following cycle
    `SCJI_ASSERT_NXT(a_tick_latency, aclk, aresetn,
        s_tvalid && s_tready && s_tuser[0] && !m_tvalid,
        m_tvalid && (m_tuser == KIND_FRAME),
        "frame result missing after tick")

    // undriven frames release every button
    `SCJI_ASSERT_IMP(a_undriven_idle, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_FRAME) && !m_tdata[8],
        m_tdata[7:0] == 8'hFF,
        "undriven frame shows pressed buttons")

    // replies carry no pad nibbles, driven flag or padding
    `SCJI_ASSERT_IMP(a_reply_clean, aclk, aresetn,
        m_tvalid && (m_tuser != KIND_FRAME),
        (m_tdata[8:0] == 9'd0) && (m_tdata[47:41] == 7'd0),
        "reply carries frame fields")

    // result kinds stop at left out
    `SCJI_ASSERT_IMP(a_kind_range, aclk, aresetn,
        m_tvalid,
        m_tuser <= KIND_LEFT_OUT,
        "result kind out of range")

endmodule

bind serial_command_joypad_injector_top scji_checker u_scji_checker (.*);
